### rtl/core/mbt_pkg.sv
// ----------------------------------------------------------------------------
// Maze backtracker package
// Sizes, codes, memory word layouts and small helper functions shared by the
// maze generator's controller and top level.
// ----------------------------------------------------------------------------
package mbt_pkg;

  // Grid and stack sizes.
  localparam int MAX_SIZE    = 64;
  localparam int COORD_W     = 6;
  localparam int SIZE_W      = 7;
  localparam int CELL_AW     = 2 * COORD_W;
  localparam int CELL_DEPTH  = MAX_SIZE * MAX_SIZE;
  localparam int CELL_W      = 2;
  localparam int STACK_DEPTH = 1024;
  localparam int STACK_AW    = 10;
  localparam int STACK_W     = 2 * COORD_W;
  localparam int LEVEL_W     = 11;
  localparam int MIN_SIZE    = 5;
  localparam int HOP         = 2;

  // Stream payload widths.
  localparam int S_TDATA_W = 24;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 40;
  localparam int M_TUSER_W = 3;

  // Input transaction kinds.
  localparam logic [1:0] MODE_RESTART = 2'd0;
  localparam logic [1:0] MODE_STEP    = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;

  // Neighbor directions, in probe order.
  localparam logic [1:0] DIR_DOWN  = 2'd0;
  localparam logic [1:0] DIR_UP    = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  // Cell memory word: bit 1 visited, bit 0 path.
  localparam int         VISITED_BIT = 1;
  localparam int         PATH_BIT    = 0;
  localparam logic [1:0] CELL_WALL   = 2'b00;
  localparam logic [1:0] CELL_PATH   = 2'b01;
  localparam logic [1:0] CELL_CARVED = 2'b11;

  // Result kinds.
  typedef enum logic [2:0] {
    ACT_RESTARTED   = 3'd0,
    ACT_CARVED      = 3'd1,
    ACT_BACKTRACKED = 3'd2,
    ACT_FINISHED    = 3'd3,
    ACT_READ        = 3'd4
  } action_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_SEED,
    ST_IDLE,
    ST_PROBE,
    ST_CHOOSE,
    ST_CARVE_TGT,
    ST_CARVE_MID,
    ST_POP_WAIT,
    ST_READ_WAIT,
    ST_EMIT
  } state_t;

  // Cell memory access from the controller.
  typedef struct packed {
    logic               we;
    logic [CELL_AW-1:0] waddr;
    logic [CELL_W-1:0]  wdata;
    logic [CELL_AW-1:0] raddr;
  } cell_req_t;

  // Stack memory access from the controller.
  typedef struct packed {
    logic                we;
    logic [STACK_AW-1:0] waddr;
    logic [STACK_W-1:0]  wdata;
    logic [STACK_AW-1:0] raddr;
  } stack_req_t;

  // Random value modulo a candidate count of 1 to 4. Since 4 is 1 mod 3,
  // the base-4 digit sum keeps the remainder by 3.
  function automatic logic [1:0] rand_mod(input logic [7:0] v, input logic [2:0] cnt);
    logic [3:0] s;
    logic [3:0] m3;
    logic [1:0] r;
    s = {2'b00, v[1:0]} + {2'b00, v[3:2]} + {2'b00, v[5:4]} + {2'b00, v[7:6]};
    priority if (s >= 4'd12) begin
      m3 = s - 4'd12;
    end else if (s >= 4'd9) begin
      m3 = s - 4'd9;
    end else if (s >= 4'd6) begin
      m3 = s - 4'd6;
    end else if (s >= 4'd3) begin
      m3 = s - 4'd3;
    end else begin
      m3 = s;
    end
    unique case (cnt)
      3'd2:    r = {1'b0, v[0]};
      3'd3:    r = m3[1:0];
      3'd4:    r = v[1:0];
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // Direction of the n-th set bit of a candidate mask, counting from bit 0.
  function automatic logic [1:0] pick_nth(input logic [3:0] mask, input logic [1:0] n);
    logic [1:0] seen;
    logic [1:0] k;
    logic       found;
    seen  = 2'd0;
    k     = 2'd0;
    found = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (mask[i] && !found) begin
        if (seen == n) begin
          k     = 2'(i);
          found = 1'b1;
        end else begin
          seen = seen + 2'd1;
        end
      end
    end
    return k;
  endfunction

endpackage

### rtl/core/mbt_ram.sv
// ----------------------------------------------------------------------------
// Maze backtracker RAM
// Simple dual-port synchronous RAM: one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module mbt_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/mbt_walk_ctrl.sv
// ----------------------------------------------------------------------------
// Maze backtracker walk controller
// Sequencer that clears the cell memory, probes the four neighbors two cells
// away, carves or pops the stack, and registers one result per transaction of modes 0 to 2.
// ----------------------------------------------------------------------------
module mbt_walk_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration
  input  logic                          cfg_wr_en,
  input  logic [mbt_pkg::SIZE_W-1:0]    cfg_wr_data,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [mbt_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic [mbt_pkg::S_TUSER_W-1:0] s_axis_tuser,
  // Output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mbt_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic [mbt_pkg::M_TUSER_W-1:0] m_axis_tuser,
  // Memories
  output mbt_pkg::cell_req_t            cell_req,
  input  logic [mbt_pkg::CELL_W-1:0]    cell_rdata,
  output mbt_pkg::stack_req_t           stack_req,
  input  logic [mbt_pkg::STACK_W-1:0]   stack_rdata
);

  localparam int CW = mbt_pkg::COORD_W;

  mbt_pkg::state_t  state;
  mbt_pkg::state_t  state_next;
  mbt_pkg::action_t res_action;

  logic [mbt_pkg::SIZE_W-1:0]  grid_size;
  logic [mbt_pkg::SIZE_W-1:0]  eff_size;
  logic [7:0]                  eff_size8;
  logic [mbt_pkg::CELL_AW-1:0] clr_addr;
  logic                        restart_pend;
  logic [CW-1:0]               cur_row;
  logic [CW-1:0]               cur_col;
  logic [mbt_pkg::LEVEL_W-1:0] top;
  logic [7:0]                  rnd;
  logic [2:0]                  probe_cnt;
  logic [1:0]                  probe_dir;
  logic [1:0]                  prev_dir;
  logic [3:0]                  cand;
  logic [CW-1:0]               tgt_row;
  logic [CW-1:0]               tgt_col;
  logic [CW-1:0]               mid_row;
  logic [CW-1:0]               mid_col;
  logic                        res_cell;

  logic [7:0]    t_row [4];
  logic [7:0]    t_col [4];
  logic [3:0]    geo_ok;
  logic [2:0]    cand_cnt;
  logic          can_carve;
  logic [1:0]    pick;
  logic [7:0]    mid_row_sum;
  logic [7:0]    mid_col_sum;
  logic [CW-1:0] centre;
  logic          seed_ok;
  logic          in_accept;
  logic          out_free;
  logic [1:0]    in_mode;
  logic [CW-1:0] out_new_row;
  logic [CW-1:0] out_new_col;
  logic [CW-1:0] out_mid_row;
  logic [CW-1:0] out_mid_col;

  // Effective grid size, clipped to the memory edge.
  assign eff_size  = (grid_size > mbt_pkg::SIZE_W'(mbt_pkg::MAX_SIZE)) ?
                     mbt_pkg::SIZE_W'(mbt_pkg::MAX_SIZE) : grid_size;
  assign eff_size8 = {1'b0, eff_size};
  assign centre    = eff_size[mbt_pkg::SIZE_W-1:1];
  assign seed_ok   = (eff_size >= mbt_pkg::SIZE_W'(mbt_pkg::MIN_SIZE));

  assign s_axis_tready = (state == mbt_pkg::ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_mode       = s_axis_tuser[1:0];
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Neighbor coordinates two cells away; values below zero wrap high and
  // fail the range check.
  always_comb begin
    t_row[mbt_pkg::DIR_DOWN]  = {2'b00, cur_row} + 8'(mbt_pkg::HOP);
    t_col[mbt_pkg::DIR_DOWN]  = {2'b00, cur_col};
    t_row[mbt_pkg::DIR_UP]    = {2'b00, cur_row} - 8'(mbt_pkg::HOP);
    t_col[mbt_pkg::DIR_UP]    = {2'b00, cur_col};
    t_row[mbt_pkg::DIR_RIGHT] = {2'b00, cur_row};
    t_col[mbt_pkg::DIR_RIGHT] = {2'b00, cur_col} + 8'(mbt_pkg::HOP);
    t_row[mbt_pkg::DIR_LEFT]  = {2'b00, cur_row};
    t_col[mbt_pkg::DIR_LEFT]  = {2'b00, cur_col} - 8'(mbt_pkg::HOP);
    for (int i = 0; i < 4; i++) begin
      geo_ok[i] = (t_row[i] != 8'd0) && (t_row[i] < eff_size8) &&
                  (t_col[i] != 8'd0) && (t_col[i] < eff_size8);
    end
  end

  // Probe sequencing: a read goes out for one direction per cycle and its
  // visited bit returns in the following cycle.
  assign probe_dir = probe_cnt[1:0];
  assign prev_dir  = probe_cnt[1:0] - 2'd1;

  // Candidate selection.
  assign cand_cnt    = 3'($countones(cand));
  assign can_carve   = (cand_cnt != 3'd0) &&
                       (top < mbt_pkg::LEVEL_W'(mbt_pkg::STACK_DEPTH));
  assign pick        = mbt_pkg::pick_nth(cand, mbt_pkg::rand_mod(rnd, cand_cnt));
  assign mid_row_sum = {2'b00, cur_row} + t_row[pick];
  assign mid_col_sum = {2'b00, cur_col} + t_col[pick];

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      mbt_pkg::ST_CLEAR: begin
        if (clr_addr == '1) begin
          state_next = restart_pend ? mbt_pkg::ST_SEED : mbt_pkg::ST_IDLE;
        end
      end
      mbt_pkg::ST_SEED: state_next = mbt_pkg::ST_EMIT;
      mbt_pkg::ST_IDLE: begin
        if (in_accept) begin
          unique case (in_mode)
            mbt_pkg::MODE_RESTART: state_next = mbt_pkg::ST_CLEAR;
            mbt_pkg::MODE_STEP:    state_next = mbt_pkg::ST_PROBE;
            mbt_pkg::MODE_READ:    state_next = mbt_pkg::ST_READ_WAIT;
            default:               state_next = mbt_pkg::ST_IDLE;
          endcase
        end
      end
      mbt_pkg::ST_PROBE: begin
        if (probe_cnt == 3'd4) begin
          state_next = mbt_pkg::ST_CHOOSE;
        end
      end
      mbt_pkg::ST_CHOOSE: begin
        priority if (can_carve) begin
          state_next = mbt_pkg::ST_CARVE_TGT;
        end else if (top != '0) begin
          state_next = mbt_pkg::ST_POP_WAIT;
        end else begin
          state_next = mbt_pkg::ST_EMIT;
        end
      end
      mbt_pkg::ST_CARVE_TGT: state_next = mbt_pkg::ST_CARVE_MID;
      mbt_pkg::ST_CARVE_MID: state_next = mbt_pkg::ST_EMIT;
      mbt_pkg::ST_POP_WAIT:  state_next = mbt_pkg::ST_EMIT;
      mbt_pkg::ST_READ_WAIT: state_next = mbt_pkg::ST_EMIT;
      mbt_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = mbt_pkg::ST_IDLE;
        end
      end
      default: state_next = mbt_pkg::ST_CLEAR;
    endcase
  end

  // Memory port control per state.
  always_comb begin
    cell_req  = '0;
    stack_req = '0;
    unique case (state)
      mbt_pkg::ST_CLEAR: begin
        cell_req.we    = 1'b1;
        cell_req.waddr = clr_addr;
        cell_req.wdata = mbt_pkg::CELL_WALL;
      end
      mbt_pkg::ST_SEED: begin
        cell_req.we     = seed_ok;
        cell_req.waddr  = {centre, centre};
        cell_req.wdata  = mbt_pkg::CELL_CARVED;
        stack_req.we    = seed_ok;
        stack_req.waddr = '0;
        stack_req.wdata = {centre, centre};
      end
      mbt_pkg::ST_IDLE: begin
        cell_req.raddr = {s_axis_tdata[13:8], s_axis_tdata[19:14]};
      end
      mbt_pkg::ST_PROBE: begin
        cell_req.raddr = {t_row[probe_dir][CW-1:0], t_col[probe_dir][CW-1:0]};
      end
      mbt_pkg::ST_CHOOSE: begin
        stack_req.raddr = 10'(top - mbt_pkg::LEVEL_W'(1));
      end
      mbt_pkg::ST_CARVE_TGT: begin
        cell_req.we     = 1'b1;
        cell_req.waddr  = {tgt_row, tgt_col};
        cell_req.wdata  = mbt_pkg::CELL_CARVED;
        stack_req.we    = 1'b1;
        stack_req.waddr = top[mbt_pkg::STACK_AW-1:0];
        stack_req.wdata = {tgt_row, tgt_col};
      end
      mbt_pkg::ST_CARVE_MID: begin
        cell_req.we    = 1'b1;
        cell_req.waddr = {mid_row, mid_col};
        cell_req.wdata = mbt_pkg::CELL_PATH;
      end
      default: begin
      end
    endcase
  end

  // Result fields for the output register.
  assign out_new_row = (res_action == mbt_pkg::ACT_READ) ? '0 : cur_row;
  assign out_new_col = (res_action == mbt_pkg::ACT_READ) ? '0 : cur_col;
  assign out_mid_row = (res_action == mbt_pkg::ACT_CARVED) ? mid_row : '0;
  assign out_mid_col = (res_action == mbt_pkg::ACT_CARVED) ? mid_col : '0;

  // Control state, walk state and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= mbt_pkg::ST_CLEAR;
      clr_addr      <= '0;
      restart_pend  <= 1'b0;
      cur_row       <= '0;
      cur_col       <= '0;
      top           <= '0;
      grid_size     <= mbt_pkg::SIZE_W'(mbt_pkg::MAX_SIZE);
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_wr_en) begin
        grid_size <= cfg_wr_data;
      end

      // Output valid rises when a result is loaded and drops once it is taken.
      if ((state == mbt_pkg::ST_EMIT) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        mbt_pkg::ST_CLEAR: begin
          clr_addr <= clr_addr + mbt_pkg::CELL_AW'(1);
        end
        mbt_pkg::ST_SEED: begin
          cur_row    <= seed_ok ? centre : '0;
          cur_col    <= seed_ok ? centre : '0;
          top        <= seed_ok ? mbt_pkg::LEVEL_W'(1) : '0;
          res_action <= mbt_pkg::ACT_RESTARTED;
          res_cell   <= 1'b0;
        end
        mbt_pkg::ST_IDLE: begin
          if (in_accept) begin
            rnd          <= s_axis_tdata[7:0];
            restart_pend <= (in_mode == mbt_pkg::MODE_RESTART);
            probe_cnt    <= '0;
            cand         <= '0;
          end
        end
        mbt_pkg::ST_PROBE: begin
          probe_cnt <= probe_cnt + 3'd1;
          if (probe_cnt != 3'd0) begin
            cand[prev_dir] <= geo_ok[prev_dir] && !cell_rdata[mbt_pkg::VISITED_BIT];
          end
        end
        mbt_pkg::ST_CHOOSE: begin
          tgt_row  <= t_row[pick][CW-1:0];
          tgt_col  <= t_col[pick][CW-1:0];
          mid_row  <= mid_row_sum[CW:1];
          mid_col  <= mid_col_sum[CW:1];
          res_cell <= 1'b0;
          if (!can_carve) begin
            if (top != '0) begin
              top <= top - mbt_pkg::LEVEL_W'(1);
            end else begin
              res_action <= mbt_pkg::ACT_FINISHED;
            end
          end
        end
        mbt_pkg::ST_CARVE_TGT: begin
          cur_row <= tgt_row;
          cur_col <= tgt_col;
          top     <= top + mbt_pkg::LEVEL_W'(1);
        end
        mbt_pkg::ST_CARVE_MID: begin
          res_action <= mbt_pkg::ACT_CARVED;
        end
        mbt_pkg::ST_POP_WAIT: begin
          cur_row    <= stack_rdata[mbt_pkg::STACK_W-1:CW];
          cur_col    <= stack_rdata[CW-1:0];
          res_action <= mbt_pkg::ACT_BACKTRACKED;
        end
        mbt_pkg::ST_READ_WAIT: begin
          res_action <= mbt_pkg::ACT_READ;
          res_cell   <= cell_rdata[mbt_pkg::PATH_BIT];
        end
        mbt_pkg::ST_EMIT: begin
          if (out_free) begin
            m_axis_tuser <= res_action;
            m_axis_tdata <= {4'b0000, top, res_cell, out_mid_col, out_mid_row,
                             out_new_col, out_new_row};
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/core/maze_backtracker_step_top.sv
// ----------------------------------------------------------------------------
// Maze backtracker step top level
// Randomized depth-first maze generator with a backtrack stack, driven one
// transaction at a time over stream ports.
// ----------------------------------------------------------------------------
// The block holds the maze in a 4096 x 2 cell memory (path and visited bits)
// and the backtrack stack in a 1024 x 12 memory, both with one write and one
// registered read port. Each input transaction gives exactly one output
// transaction, except mode 3, which does nothing. After reset, and for every
// restart, a clearing pass writes all 4096 cells, one per cycle, and no input
// is taken meanwhile. A step does four serial probe reads of the cell memory,
// a select step, then two cell writes and a stack push for a carve, one stack
// read for a backtrack, or nothing more when the walk is finished. A read does
// one cell memory read. One transaction is worked on at a time; the next one is
// taken while the previous result still waits in the output register.
// grid_size may only be written while the block is idle.
// ----------------------------------------------------------------------------
module maze_backtracker_step_top (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration: grid_size
  input  logic                          cfg_wr_en,
  input  logic [mbt_pkg::SIZE_W-1:0]    cfg_wr_data,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] rand_value, [13:8] read_row, [19:14] read_col, [23:20] zero
  input  logic [mbt_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [1:0] mode
  input  logic [mbt_pkg::S_TUSER_W-1:0] s_axis_tuser,
  // Output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [5:0] new_row, [11:6] new_col, [17:12] between_row, [23:18] between_col,
  // [24] cell_value, [35:25] stack_level, [39:36] zero
  output logic [mbt_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // [2:0] action
  output logic [mbt_pkg::M_TUSER_W-1:0] m_axis_tuser
);

  mbt_pkg::cell_req_t  cell_req;
  mbt_pkg::stack_req_t stack_req;
  logic [mbt_pkg::CELL_W-1:0]  cell_rdata;
  logic [mbt_pkg::STACK_W-1:0] stack_rdata;

  // Walk sequencer and output register.
  mbt_walk_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cell_req      (cell_req),
    .cell_rdata    (cell_rdata),
    .stack_req     (stack_req),
    .stack_rdata   (stack_rdata)
  );

  // Maze cell memory: path and visited bits.
  mbt_ram #(
    .WIDTH (mbt_pkg::CELL_W),
    .DEPTH (mbt_pkg::CELL_DEPTH)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_req.we),
    .waddr (cell_req.waddr),
    .wdata (cell_req.wdata),
    .raddr (cell_req.raddr),
    .rdata (cell_rdata)
  );

  // Backtrack stack memory: row and column of each pushed position.
  mbt_ram #(
    .WIDTH (mbt_pkg::STACK_W),
    .DEPTH (mbt_pkg::STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stack_req.we),
    .waddr (stack_req.waddr),
    .wdata (stack_req.wdata),
    .raddr (stack_req.raddr),
    .rdata (stack_rdata)
  );

endmodule

### test/maze_walk_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Maze walk checker
// Watches the configuration port and both stream channels of the maze
// backtracker. It keeps its own maze, visited map and backtrack stack and
// predicts every result. Each output transaction is compared field by field
// with the oldest prediction.
// ----------------------------------------------------------------------------
module maze_walk_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [mbt_pkg::SIZE_W-1:0]    cfg_wr_data,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  // [7:0] rand_value, [13:8] read_row, [19:14] read_col, [23:20] zero
  input  logic [mbt_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [1:0] mode
  input  logic [mbt_pkg::S_TUSER_W-1:0] s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [5:0] new_row, [11:6] new_col, [17:12] between_row, [23:18] between_col,
  // [24] cell_value, [35:25] stack_level, [39:36] zero
  input  logic [mbt_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // [2:0] action
  input  logic [mbt_pkg::M_TUSER_W-1:0] m_axis_tuser,
  output int                            outstanding,
  output int                            fail_count
);

  // One predicted output transaction.
  typedef struct {
    mbt_pkg::action_t            act;
    logic [mbt_pkg::COORD_W-1:0] new_row;
    logic [mbt_pkg::COORD_W-1:0] new_col;
    logic [mbt_pkg::COORD_W-1:0] mid_row;
    logic [mbt_pkg::COORD_W-1:0] mid_col;
    logic                        cell_bit;
    logic [mbt_pkg::LEVEL_W-1:0] level;
  } maze_outcome_t;

  maze_outcome_t expected_outcomes[$];

  // Shadow copy of the block's state.
  bit [mbt_pkg::CELL_DEPTH-1:0] maze_path;
  bit [mbt_pkg::CELL_DEPTH-1:0] visited;
  logic [mbt_pkg::COORD_W-1:0]  stack_row [mbt_pkg::STACK_DEPTH];
  logic [mbt_pkg::COORD_W-1:0]  stack_col [mbt_pkg::STACK_DEPTH];
  int                           level;
  int                           pos_row;
  int                           pos_col;
  logic [mbt_pkg::SIZE_W-1:0]   grid_size;
  int                           result_idx;

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    fail_count++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                result_idx, name, got, want));
    end
  endtask

  // Cell two away from (r, c) in the given direction.
  function automatic void hop_target(input logic [1:0] dir, input int r, input int c,
                                     output int tr, output int tc);
    tr = r;
    tc = c;
    case (dir)
      mbt_pkg::DIR_DOWN:  tr = r + mbt_pkg::HOP;
      mbt_pkg::DIR_UP:    tr = r - mbt_pkg::HOP;
      mbt_pkg::DIR_RIGHT: tc = c + mbt_pkg::HOP;
      mbt_pkg::DIR_LEFT:  tc = c - mbt_pkg::HOP;
    endcase
  endfunction

  // Applies one input transaction to the shadow state and queues its result.
  task automatic predict_outcome(input logic [1:0] mode, input logic [7:0] rnd,
                                 input logic [mbt_pkg::COORD_W-1:0] rr,
                                 input logic [mbt_pkg::COORD_W-1:0] rc);
    maze_outcome_t o;
    logic [1:0]    cand [4];
    int            d;
    int            n;
    int            tr;
    int            tc;
    int            br;
    int            bc;
    o.act      = mbt_pkg::ACT_READ;
    o.new_row  = '0;
    o.new_col  = '0;
    o.mid_row  = '0;
    o.mid_col  = '0;
    o.cell_bit = 1'b0;
    d = (int'(grid_size) > mbt_pkg::MAX_SIZE) ? mbt_pkg::MAX_SIZE : int'(grid_size);
    case (mode)
      mbt_pkg::MODE_RESTART: begin
        maze_path = '0;
        visited   = '0;
        level     = 0;
        pos_row   = 0;
        pos_col   = 0;
        // Grids below the minimum size are only cleared.
        if (d >= mbt_pkg::MIN_SIZE) begin
          pos_row = d / 2;
          pos_col = d / 2;
          maze_path[pos_row * mbt_pkg::MAX_SIZE + pos_col] = 1'b1;
          visited[pos_row * mbt_pkg::MAX_SIZE + pos_col]   = 1'b1;
          stack_row[0] = mbt_pkg::COORD_W'(pos_row);
          stack_col[0] = mbt_pkg::COORD_W'(pos_col);
          level = 1;
        end
        o.act = mbt_pkg::ACT_RESTARTED;
      end
      mbt_pkg::MODE_STEP: begin
        // Collect unvisited cells two away, strictly inside the grid.
        n = 0;
        for (int i = 0; i < 4; i++) begin
          hop_target(2'(i), pos_row, pos_col, tr, tc);
          if (tr > 0 && tr < d && tc > 0 && tc < d &&
              !visited[tr * mbt_pkg::MAX_SIZE + tc]) begin
            cand[n] = 2'(i);
            n++;
          end
        end
        // A full stack forces a backtrack even with candidates left.
        if (n > 0 && level < mbt_pkg::STACK_DEPTH) begin
          hop_target(cand[int'(rnd) % n], pos_row, pos_col, tr, tc);
          br = (pos_row + tr) / 2;
          bc = (pos_col + tc) / 2;
          maze_path[tr * mbt_pkg::MAX_SIZE + tc] = 1'b1;
          maze_path[br * mbt_pkg::MAX_SIZE + bc] = 1'b1;
          visited[tr * mbt_pkg::MAX_SIZE + tc]   = 1'b1;
          stack_row[level] = mbt_pkg::COORD_W'(tr);
          stack_col[level] = mbt_pkg::COORD_W'(tc);
          level++;
          pos_row   = tr;
          pos_col   = tc;
          o.act     = mbt_pkg::ACT_CARVED;
          o.mid_row = mbt_pkg::COORD_W'(br);
          o.mid_col = mbt_pkg::COORD_W'(bc);
        end else if (level > 0) begin
          // The pop moves to the entry just removed.
          level--;
          pos_row = int'(stack_row[level]);
          pos_col = int'(stack_col[level]);
          o.act   = mbt_pkg::ACT_BACKTRACKED;
        end else begin
          o.act = mbt_pkg::ACT_FINISHED;
        end
      end
      mbt_pkg::MODE_READ: begin
        o.cell_bit = maze_path[int'(rr) * mbt_pkg::MAX_SIZE + int'(rc)];
      end
      default: begin
        // The unused mode gives no result.
        return;
      end
    endcase
    if (mode != mbt_pkg::MODE_READ) begin
      o.new_row = mbt_pkg::COORD_W'(pos_row);
      o.new_col = mbt_pkg::COORD_W'(pos_col);
    end
    o.level = mbt_pkg::LEVEL_W'(level);
    expected_outcomes.push_back(o);
  endtask

  // Track configuration writes and both channels at every clock edge.
  always @(posedge clk) begin : track
    maze_outcome_t want;
    if (rst) begin
      maze_path  = '0;
      visited    = '0;
      level      = 0;
      pos_row    = 0;
      pos_col    = 0;
      grid_size  = mbt_pkg::SIZE_W'(mbt_pkg::MAX_SIZE);
      result_idx = 0;
      fail_count = 0;
      expected_outcomes.delete();
    end else begin
      if (cfg_wr_en) begin
        grid_size = cfg_wr_data;
      end
      // Results are compared before the input of the same edge is predicted.
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_outcomes.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no transaction pending",
                                    result_idx));
        end else begin
          want = expected_outcomes.pop_front();
          compare_field("action", 16'(m_axis_tuser), 16'(want.act));
          compare_field("new_row", 16'(m_axis_tdata[5:0]), 16'(want.new_row));
          compare_field("new_col", 16'(m_axis_tdata[11:6]), 16'(want.new_col));
          compare_field("between_row", 16'(m_axis_tdata[17:12]), 16'(want.mid_row));
          compare_field("between_col", 16'(m_axis_tdata[23:18]), 16'(want.mid_col));
          compare_field("cell_value", 16'(m_axis_tdata[24]), 16'(want.cell_bit));
          compare_field("stack_level", 16'(m_axis_tdata[35:25]), 16'(want.level));
        end
        result_idx++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_outcome(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[13:8],
                        s_axis_tdata[19:14]);
      end
    end
    outstanding <= expected_outcomes.size();
  end

endmodule

### test/tb_maze_backtracker_step_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Maze backtracker step testbench
// Drives restart, step, read and unused transactions into the maze generator
// over a range of grid sizes, with random gaps on both stream channels and
// one long output stall. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_maze_backtracker_step_top;

  localparam int         CLK_PERIOD     = 8;
  localparam int         RESET_CYCLES   = 9;
  localparam int         WATCHDOG_LIMIT = 20000;
  localparam int         SETTLE_CYCLES  = 20;
  localparam int         HOLD_CYCLES    = 400;
  localparam int         ITEM_TARGET    = 1800;
  localparam int         CALM_ITEMS     = 200;
  localparam int         PRESSURE_AT    = 150;
  localparam logic [1:0] MODE_UNUSED    = 2'd3;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_wr_en;
  logic [mbt_pkg::SIZE_W-1:0]    cfg_wr_data;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  // [7:0] rand_value, [13:8] read_row, [19:14] read_col, [23:20] zero
  logic [mbt_pkg::S_TDATA_W-1:0] s_axis_tdata;
  // [1:0] mode
  logic [mbt_pkg::S_TUSER_W-1:0] s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  // [5:0] new_row, [11:6] new_col, [17:12] between_row, [23:18] between_col,
  // [24] cell_value, [35:25] stack_level, [39:36] zero
  logic [mbt_pkg::M_TDATA_W-1:0] m_axis_tdata;
  // [2:0] action
  logic [mbt_pkg::M_TUSER_W-1:0] m_axis_tuser;

  int outstanding;
  int fail_count;
  int idle_cycles   = 0;
  int items_sent    = 0;
  int cur_size      = mbt_pkg::MAX_SIZE;
  bit calm          = 1'b0;
  bit hold_req      = 1'b0;
  bit pressure_done = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  maze_backtracker_step_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  maze_walk_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .outstanding   (outstanding),
    .fail_count    (fail_count)
  );

  // Watchdog: ends the run after too many cycles without a transaction.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: random ready bursts, one long hold-off on request.
  initial begin : result_sink
    m_axis_tready <= 1'b0;
    wait (!rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Offers one transaction, maybe after a gap, and waits until it is taken.
  task automatic send_item(input logic [1:0] mode, input logic [7:0] rnd,
                           input logic [mbt_pkg::COORD_W-1:0] row,
                           input logic [mbt_pkg::COORD_W-1:0] col);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {4'b0000, col, row, rnd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (mode != MODE_UNUSED) begin
      items_sent++;
    end
  endtask

  // Writes grid_size once the block has drained and settled.
  task automatic set_grid_size(input int size);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mbt_pkg::SIZE_W'(size);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_size = size;
  endtask

  // Mostly walk steps, with reads, unused items and rare restarts mixed in.
  task automatic send_random_item();
    int span;
    int pick;
    span = (cur_size > mbt_pkg::MAX_SIZE) ? mbt_pkg::MAX_SIZE :
           ((cur_size < 1) ? 1 : cur_size);
    pick = $urandom_range(0, 99);
    if (pick < 86) begin
      send_item(mbt_pkg::MODE_STEP, 8'($urandom), 6'($urandom), 6'($urandom));
    end else if (pick < 95) begin
      if ($urandom_range(0, 1) == 0) begin
        send_item(mbt_pkg::MODE_READ, 8'($urandom), 6'($urandom_range(0, span - 1)),
                  6'($urandom_range(0, span - 1)));
      end else begin
        send_item(mbt_pkg::MODE_READ, 8'($urandom), 6'($urandom), 6'($urandom));
      end
    end else if (pick < 99) begin
      send_item(MODE_UNUSED, 8'($urandom), 6'($urandom), 6'($urandom));
    end else begin
      send_item(mbt_pkg::MODE_RESTART, 8'($urandom), 6'($urandom), 6'($urandom));
    end
  endtask

  initial begin : stimulus
    int pick;
    int size;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= mbt_pkg::MODE_RESTART;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Before any restart: the walk is already finished and the maze is empty.
    send_item(mbt_pkg::MODE_STEP, 8'h00, 6'd0, 6'd0);
    send_item(mbt_pkg::MODE_READ, 8'hff, 6'd0, 6'd0);
    send_item(mbt_pkg::MODE_READ, 8'h00, 6'd63, 6'd63);
    send_item(MODE_UNUSED, 8'hff, 6'd63, 6'd63);

    // Restart at the reset size and take a few steps.
    send_item(mbt_pkg::MODE_RESTART, 8'h00, 6'd0, 6'd0);
    send_item(mbt_pkg::MODE_STEP, 8'hff, 6'd63, 6'd0);
    send_item(mbt_pkg::MODE_STEP, 8'h00, 6'd0, 6'd63);
    send_item(mbt_pkg::MODE_READ, 8'h5a, 6'd32, 6'd32);

    // Grids too small to carve anything.
    set_grid_size(mbt_pkg::MIN_SIZE - 1);
    send_item(mbt_pkg::MODE_RESTART, 8'h00, 6'd0, 6'd0);
    send_item(mbt_pkg::MODE_STEP, 8'h33, 6'd0, 6'd0);
    send_item(mbt_pkg::MODE_READ, 8'h00, 6'd32, 6'd32);
    set_grid_size(0);
    send_item(mbt_pkg::MODE_RESTART, 8'hff, 6'd63, 6'd63);
    send_item(mbt_pkg::MODE_STEP, 8'hcc, 6'd0, 6'd0);

    // An oversized grid acts as the largest one.
    set_grid_size((1 << mbt_pkg::SIZE_W) - 1);
    send_item(mbt_pkg::MODE_RESTART, 8'h00, 6'd0, 6'd0);
    send_item(mbt_pkg::MODE_STEP, 8'haa, 6'd0, 6'd0);
    send_item(mbt_pkg::MODE_STEP, 8'h55, 6'd0, 6'd0);
    send_item(mbt_pkg::MODE_READ, 8'h00, 6'd32, 6'd33);

    // Smallest carving grid, walked to the end.
    set_grid_size(mbt_pkg::MIN_SIZE);
    send_item(mbt_pkg::MODE_RESTART, 8'h00, 6'd0, 6'd0);
    repeat (8) send_item(mbt_pkg::MODE_STEP, 8'($urandom), 6'd0, 6'd0);

    // Random phases: a new size each time, usually with a restart. Without
    // one, the walk goes on under the new size.
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        size = $urandom_range(mbt_pkg::MIN_SIZE, 15);
      end else if (pick < 80) begin
        size = $urandom_range(16, mbt_pkg::MAX_SIZE);
      end else if (pick < 90) begin
        size = $urandom_range(mbt_pkg::MAX_SIZE + 1, (1 << mbt_pkg::SIZE_W) - 1);
      end else begin
        size = $urandom_range(0, mbt_pkg::MIN_SIZE - 1);
      end
      set_grid_size(size);
      if ($urandom_range(0, 4) != 0) begin
        send_item(mbt_pkg::MODE_RESTART, 8'($urandom), 6'($urandom), 6'($urandom));
      end
      repeat ($urandom_range(20, 120)) begin
        if (items_sent >= ITEM_TARGET - CALM_ITEMS) begin
          calm = 1'b1;
        end
        if (!pressure_done && items_sent >= PRESSURE_AT) begin
          hold_req      = 1'b1;
          pressure_done = 1'b1;
        end
        send_random_item();
      end
    end

    // Drain, let the block settle, then give the verdict.
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
